### hdl/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;
  localparam int WordBits = 32;
  localparam int OpBits = 3;

  typedef enum logic [OpBits-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_SIMPLIFY = 3'd4
  } op_t;

  typedef struct packed {
    logic [OpBits-1:0] operation;
    logic signed [WordBits-1:0] a_num;
    logic signed [WordBits-1:0] a_den;
    logic signed [WordBits-1:0] b_num;
    logic signed [WordBits-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [WordBits-1:0] result_num;
    logic signed [WordBits-1:0] result_den;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_COMBINE,
    ST_GCD_TEST,
    ST_GCD_DIV,
    ST_QN_DIV,
    ST_QD_DIV,
    ST_DONE
  } state_t;
endpackage

### hdl/rau_divider.sv
`timescale 1ns / 1ps
// Restoring signed divider, one quotient bit per cycle. Truncating quotient,
// remainder takes the sign of the dividend. Divisor must be nonzero.
module rau_divider
  import rau_pkg::*;
#(
  parameter int WORD_BITS = WordBits
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  output logic                 done,
  output logic [WORD_BITS-1:0] quotient,
  output logic [WORD_BITS-1:0] remainder
);
  localparam int CntBits = $clog2(WORD_BITS + 1);

  logic                 busy;
  logic [WORD_BITS-1:0] q;
  logic [WORD_BITS:0]   r;
  logic [WORD_BITS-1:0] d;
  logic                 q_neg;
  logic                 r_neg;
  logic [CntBits-1:0]   cnt;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   shifted;

  // Shift in next dividend bit and try a subtract
  always_comb begin
    shifted = {r[WORD_BITS-1:0], q[WORD_BITS-1]};
    trial   = shifted - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CntBits'(WORD_BITS);
        q     <= dividend[WORD_BITS-1] ? -dividend : dividend;
        d     <= divisor[WORD_BITS-1] ? -divisor : divisor;
        r     <= '0;
        q_neg <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
        r_neg <= dividend[WORD_BITS-1];
      end else if (busy) begin
        if (trial[WORD_BITS]) begin
          r <= shifted;
          q <= {q[WORD_BITS-2:0], 1'b0};
        end else begin
          r <= trial;
          q <= {q[WORD_BITS-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q_neg ? -q : q;
  assign remainder = r_neg ? -r[WORD_BITS-1:0] : r[WORD_BITS-1:0];
endmodule

### hdl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Rational arithmetic unit: one fraction result per item. Add, subtract,
// multiply and divide pass through states MUL0, MUL1, MUL2 and COMBINE from
// acceptance to result valid, using a single shared multiplier three times;
// undefined operation codes return A in the cycle after acceptance. Simplify
// runs Euclid's algorithm on a shared bit-serial divider, one remainder step
// per division, then two more divisions; a 32-bit item needs at most about 46
// remainder steps. Input is not ready while an item is in work; the result
// is held until taken, and the next item is accepted in the same cycle it
// is taken.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int WORD_BITS = WordBits
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  localparam int W = WORD_BITS;

  state_t state, state_next;
  logic [OpBits-1:0] op;
  logic [W-1:0] an, ad, bn, bd;
  logic [W-1:0] p0, p1;
  logic [W-1:0] ga, gb, rn, rd;
  logic [W-1:0] mul_x, mul_y, mul_p;
  logic [W-1:0] div_n, div_d, div_q, div_r;
  logic div_start, div_done;
  logic take;

  assign take = in_valid && in_ready;

  // Shared multiplier, product registered
  always_comb begin
    mul_x = an;
    mul_y = bd;
    case (state)
      ST_MUL0: begin mul_x = an; mul_y = (op == OP_MUL) ? bn : bd; end
      ST_MUL1: begin mul_x = ad; mul_y = (op == OP_DIV) ? bn : bd; end
      ST_MUL2: begin mul_x = ad; mul_y = bn; end
      default: ;
    endcase
  end
  always_ff @(posedge clk) mul_p <= W'(mul_x * mul_y);

  rau_divider #(.WORD_BITS(W)) u_div (
    .clk, .rst, .start(div_start), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take) begin
        case (in_data.operation)
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_next = ST_MUL0;
          OP_SIMPLIFY: state_next = ST_GCD_TEST;
          default: state_next = ST_DONE;
        endcase
      end
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_COMBINE;
      ST_COMBINE: state_next = ST_DONE;
      ST_GCD_TEST: begin
        if (gb != '0) state_next = ST_GCD_DIV;
        else if (ga == '0) state_next = ST_DONE;
        else state_next = ST_QN_DIV;
      end
      ST_GCD_DIV: if (div_done) state_next = ST_GCD_TEST;
      ST_QN_DIV: if (div_done) state_next = ST_QD_DIV;
      ST_QD_DIV: if (div_done) state_next = ST_DONE;
      ST_DONE: if (out_ready) state_next = take ? (in_data.operation == OP_SIMPLIFY ?
          ST_GCD_TEST : (in_data.operation <= OP_DIV ? ST_MUL0 : ST_DONE)) : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and divider control
  always_comb begin
    in_ready  = (state == ST_IDLE) || (state == ST_DONE && out_ready);
    out_valid = (state == ST_DONE);
    out_data.result_num = rn;
    out_data.result_den = rd;
    div_n = ga;
    div_d = gb;
    div_start = 1'b0;
    case (state)
      ST_GCD_TEST: begin
        div_start = (gb != '0) || (ga != '0);
        if (gb == '0) begin div_n = an; div_d = ga; end
      end
      ST_QN_DIV: begin
        div_n = ad; div_d = ga; div_start = div_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (take) begin
      op <= in_data.operation;
      an <= in_data.a_num;
      ad <= in_data.a_den;
      bn <= in_data.b_num;
      bd <= in_data.b_den;
      ga <= in_data.a_num;
      gb <= in_data.a_den;
      rn <= in_data.a_num;
      rd <= in_data.a_den;
    end else begin
      case (state)
        ST_MUL1: p0 <= mul_p;
        ST_MUL2: p1 <= mul_p;
        ST_COMBINE: begin
          case (op)
            OP_ADD: begin rn <= p0 + mul_p; rd <= p1; end
            OP_SUB: begin rn <= p0 - mul_p; rd <= p1; end
            default: begin rn <= p0; rd <= p1; end
          endcase
        end
        ST_GCD_DIV: if (div_done) begin ga <= gb; gb <= div_r; end
        ST_QN_DIV: if (div_done) rn <= div_q;
        ST_QD_DIV: if (div_done) rd <= div_q;
        default: ;
      endcase
    end
  end
endmodule

### hdl/rau_checker.sv
`timescale 1ns / 1ps
module rau_checker
  import rau_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  // No new item while a result waits untaken
  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input ready while result stalled");
  // An accepted item is either in work or already showing its result
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready || out_valid)
    else $error("second item accepted before a result");
  // Idle after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
